// ===== rtl/core/three_axis_moving_average_minmax_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the three-axis moving average block
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_MOVING_AVERAGE_MINMAX_TOP_ASSERT_SVH
`define THREE_AXIS_MOVING_AVERAGE_MINMAX_TOP_ASSERT_SVH

// property checked on every clock edge outside reset
`define TAMAM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// property checked on every clock edge, reset included
`define TAMAM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/tamam_pkg.sv =====
// ----------------------------------------------------------------------------
// tamam_pkg
// Types, widths and constants of the three-axis moving average block.
// ----------------------------------------------------------------------------
package tamam_pkg;

    localparam int WINDOW    = 10;
    localparam int SAMPLE_W  = 16;
    localparam int CORR_W    = SAMPLE_W + 1;
    localparam int WIN_LOG   = $clog2(WINDOW);
    localparam int SUM_W     = SAMPLE_W + WIN_LOG;

    // truncating divide by WINDOW as multiply by rounded-up reciprocal and shift,
    // exact for every magnitude below 2**SUM_W
    localparam int DIV_SHIFT = SUM_W + WIN_LOG;
    localparam int MUL_W     = SUM_W + 1;
    localparam int PROD_W    = SUM_W + MUL_W;
    localparam longint DIV_MUL_L = ((longint'(1) << DIV_SHIFT) + WINDOW - 1) / WINDOW;
    localparam logic [MUL_W-1:0] DIV_MUL = MUL_W'(DIV_MUL_L);

    localparam int ADDR_W = 2;
    localparam int CFG_W  = SAMPLE_W;

    typedef enum logic [ADDR_W-1:0] {
        REG_OFFSET_X = 2'd0,
        REG_OFFSET_Y = 2'd1,
        REG_OFFSET_Z = 2'd2
    } reg_idx_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [CORR_W-1:0]   corr_t;

    typedef struct packed {
        sample_t z;
        sample_t y;
        sample_t x;
    } sample_vec_t;

    // last field in the lowest bits
    typedef struct packed {
        sample_t max_z;
        sample_t max_y;
        sample_t max_x;
        sample_t min_z;
        sample_t min_y;
        sample_t min_x;
        corr_t   corr_z;
        corr_t   corr_y;
        corr_t   corr_x;
        sample_t avg_z;
        sample_t avg_y;
        sample_t avg_x;
    } result_t;

    localparam int SAMPLES_W = $bits(sample_vec_t);
    localparam int RESULT_W  = $bits(result_t);
    localparam int S_TDATA_W = ((SAMPLES_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    // stage load strobes of the result pipeline
    typedef struct packed {
        logic ld_sum;
        logic ld_prod;
        logic ld_avg;
        logic ld_out;
    } stage_en_t;

endpackage

// ===== rtl/core/tamam_cell.sv =====
// ----------------------------------------------------------------------------
// tamam_cell
// One tap of the sample window, holding one sample of each axis.
// ----------------------------------------------------------------------------
module tamam_cell import tamam_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        shift_en,
    input  sample_vec_t tap_in,
    output sample_vec_t tap_out
);

    sample_vec_t tap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_reg <= '0;
        end else if (shift_en) begin
            tap_reg <= tap_in;
        end
    end

    assign tap_out = tap_reg;

endmodule

// ===== rtl/core/tamam_div.sv =====
// ----------------------------------------------------------------------------
// tamam_div
// Running window sum of one axis and truncating divide by the window length.
// ----------------------------------------------------------------------------
module tamam_div import tamam_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  stage_en_t en,
    input  sample_t   new_sample,
    input  sample_t   old_sample,
    output sample_t   avg
);

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W-1:0]        mag;
    logic [PROD_W-1:0]       prod;
    logic [PROD_W-1:0]       prod_reg;
    logic                    neg_reg;
    logic [SAMPLE_W-1:0]     quo;
    sample_t                 avg_reg, avg_next;

    // newest sample in, oldest out
    assign sum_next = sum_reg + SUM_W'(new_sample) - SUM_W'(old_sample);

    assign mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign prod = mag * DIV_MUL;

    assign quo      = prod_reg[DIV_SHIFT +: SAMPLE_W];
    assign avg_next = neg_reg ? sample_t'(-quo) : sample_t'(quo);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (en.ld_sum) begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.ld_prod) begin
            prod_reg <= prod;
            neg_reg  <= sum_reg[SUM_W-1];
        end
        if (en.ld_avg) begin
            avg_reg <= avg_next;
        end
    end

    assign avg = avg_reg;

endmodule

// ===== rtl/core/tamam_track.sv =====
// ----------------------------------------------------------------------------
// tamam_track
// Low and high marks of one axis average, offset correction, output register.
// ----------------------------------------------------------------------------
module tamam_track import tamam_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  stage_en_t en,
    input  sample_t   avg_in,
    input  sample_t   offset,
    output sample_t   avg_out,
    output corr_t     corr,
    output sample_t   low_mark,
    output sample_t   high_mark
);

    sample_t avg_reg;
    corr_t   corr_reg, corr_next;
    sample_t low_reg, low_next;
    sample_t high_reg, high_next;

    assign corr_next = CORR_W'(avg_in) - CORR_W'(offset);
    assign low_next  = (avg_in < low_reg)  ? avg_in : low_reg;
    assign high_next = (avg_in > high_reg) ? avg_in : high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= '0;
            high_reg <= '0;
        end else if (en.ld_out) begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.ld_out) begin
            avg_reg  <= avg_in;
            corr_reg <= corr_next;
        end
    end

    assign avg_out   = avg_reg;
    assign corr      = corr_reg;
    assign low_mark  = low_reg;
    assign high_mark = high_reg;

endmodule

// ===== rtl/core/three_axis_moving_average_minmax_top.sv =====
// Three-axis moving average with min/max tracking. Each accepted item carries
// one x, y, z sample; the block shifts it into a row of WINDOW window cells and
// returns, per axis, the window average truncated toward zero, that average
// minus the configured offset, and the running low and high marks of the
// average (both start at zero). One item per clock is sustained while m_tready
// stays high; a result passes the four-register path: running sum, reciprocal
// multiply, average, output register. Each stage advances on its own, so empty
// stages close up while the output is stalled. The user writes offsets through
// the cfg port only while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
// three_axis_moving_average_minmax_top
// Top level: window cell chain, per-axis divide and tracking, stream control.
// ----------------------------------------------------------------------------
module three_axis_moving_average_minmax_top import tamam_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // sample_x, sample_y, sample_z
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // avg_x, avg_y, avg_z, corr_x, corr_y, corr_z,
    // min_x, min_y, min_z, max_x, max_y, max_z, zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [ADDR_W-1:0]    cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    sample_vec_t in_samples;
    sample_vec_t taps [WINDOW];
    sample_vec_t oldest;
    sample_vec_t avgs;
    stage_en_t   en;
    result_t     res;

    logic    v_sum_reg, v_sum_next;
    logic    v_prod_reg, v_prod_next;
    logic    v_avg_reg, v_avg_next;
    logic    m_valid_reg, m_valid_next;
    sample_t off_x_reg, off_y_reg, off_z_reg;

    assign in_samples = sample_vec_t'(s_tdata[SAMPLES_W-1:0]);

    // stream control
    always_comb begin
        en.ld_out  = v_avg_reg && (!m_valid_reg || m_tready);
        en.ld_avg  = v_prod_reg && (!v_avg_reg || en.ld_out);
        en.ld_prod = v_sum_reg && (!v_prod_reg || en.ld_avg);
        s_tready   = !v_sum_reg || en.ld_prod;
        en.ld_sum  = s_tvalid && s_tready;

        v_sum_next   = en.ld_sum  ? 1'b1 : (en.ld_prod ? 1'b0 : v_sum_reg);
        v_prod_next  = en.ld_prod ? 1'b1 : (en.ld_avg  ? 1'b0 : v_prod_reg);
        v_avg_next   = en.ld_avg  ? 1'b1 : (en.ld_out  ? 1'b0 : v_avg_reg);
        m_valid_next = en.ld_out  ? 1'b1 : (m_tready   ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_sum_reg   <= 1'b0;
            v_prod_reg  <= 1'b0;
            v_avg_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v_sum_reg   <= v_sum_next;
            v_prod_reg  <= v_prod_next;
            v_avg_reg   <= v_avg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // offset registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_x_reg <= '0;
            off_y_reg <= '0;
            off_z_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_OFFSET_X: off_x_reg <= sample_t'(cfg_wdata);
                REG_OFFSET_Y: off_y_reg <= sample_t'(cfg_wdata);
                REG_OFFSET_Z: off_z_reg <= sample_t'(cfg_wdata);
                default: ;
            endcase
        end
    end

    // window cell chain, newest sample at the head
    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        if (g == 0) begin : g_head
            tamam_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (en.ld_sum),
                .tap_in   (in_samples),
                .tap_out  (taps[g])
            );
        end else begin : g_body
            tamam_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (en.ld_sum),
                .tap_in   (taps[g-1]),
                .tap_out  (taps[g])
            );
        end
    end

    // sample that drops out of the window on this shift
    assign oldest = taps[WINDOW-1];

    tamam_div u_div_x (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .new_sample (in_samples.x),
        .old_sample (oldest.x),
        .avg        (avgs.x)
    );

    tamam_div u_div_y (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .new_sample (in_samples.y),
        .old_sample (oldest.y),
        .avg        (avgs.y)
    );

    tamam_div u_div_z (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .new_sample (in_samples.z),
        .old_sample (oldest.z),
        .avg        (avgs.z)
    );

    tamam_track u_track_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .avg_in    (avgs.x),
        .offset    (off_x_reg),
        .avg_out   (res.avg_x),
        .corr      (res.corr_x),
        .low_mark  (res.min_x),
        .high_mark (res.max_x)
    );

    tamam_track u_track_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .avg_in    (avgs.y),
        .offset    (off_y_reg),
        .avg_out   (res.avg_y),
        .corr      (res.corr_y),
        .low_mark  (res.min_y),
        .high_mark (res.max_y)
    );

    tamam_track u_track_z (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .avg_in    (avgs.z),
        .offset    (off_z_reg),
        .avg_out   (res.avg_z),
        .corr      (res.corr_z),
        .low_mark  (res.min_z),
        .high_mark (res.max_z)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(res);

endmodule

// ===== rtl/core/tamam_checker.sv =====
// ----------------------------------------------------------------------------
// tamam_checker
// Port-level checks of the three-axis moving average block.
// ----------------------------------------------------------------------------
`include "three_axis_moving_average_minmax_top_assert.svh"

module tamam_checker import tamam_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    result_t res;
    logic    bracket_ok;
    logic    span_ok;
    logic    stalled;

    assign res = result_t'(m_tdata[RESULT_W-1:0]);

    // every shown average lies between the marks that include it
    assign bracket_ok = !m_tvalid ||
        ((res.min_x <= res.avg_x) && (res.avg_x <= res.max_x) &&
         (res.min_y <= res.avg_y) && (res.avg_y <= res.max_y) &&
         (res.min_z <= res.avg_z) && (res.avg_z <= res.max_z));

    // marks start at zero so they never cross it
    assign span_ok = !m_tvalid ||
        ((res.min_x <= 0) && (res.max_x >= 0) &&
         (res.min_y <= 0) && (res.max_y >= 0) &&
         (res.min_z <= 0) && (res.max_z >= 0));

    assign stalled = m_tvalid && !m_tready;

    `TAMAM_ASSERT(a_marks_bracket_avg, aclk, aresetn, bracket_ok, "average outside its marks")

    `TAMAM_ASSERT(a_marks_span_zero, aclk, aresetn, span_ok, "mark crossed zero")

    `TAMAM_ASSERT(a_stall_holds_item, aclk, aresetn, stalled |=> m_tvalid && $stable(m_tdata), "item lost")

    `TAMAM_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "valid after reset")

endmodule

bind three_axis_moving_average_minmax_top tamam_checker u_tamam_checker (.*);

// ===== tb/three_axis_moving_average_minmax_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_moving_average_minmax_top_tb
// Self-checking bench for the three-axis moving average and min/max tracker.
// A queue-fed driver streams x/y/z samples with random gaps, and the sink
// applies random backpressure. A cycle-free model of the window, the
// truncating divide, the offset correction and the running low/high marks
// predicts each result, which the monitor compares field by field. Offsets
// are rewritten between phases while the block is drained, and the sample
// amplitude grows from phase to phase so that the marks keep moving.
// ----------------------------------------------------------------------------
module three_axis_moving_average_minmax_top_tb;
    import tamam_pkg::*;

    localparam logic [ADDR_W-1:0] REG_NONE   = 2'd3;   // unmapped index
    localparam sample_t           SAMPLE_MAX = 16'sh7fff;
    localparam sample_t           SAMPLE_MIN = 16'sh8000;
    localparam int                DRAIN_WAIT = 8;      // extra wait after the last result is back
    localparam int                STALL_LIMIT = 2000;
    localparam int                NUM_FIELDS = 12;
    localparam int                REPORT_MAX = 10;

    typedef int field_arr_t [NUM_FIELDS];

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [ADDR_W-1:0]    cfg_addr  = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // filter model state
    sample_t win [3][WINDOW];
    sample_t low_mark [3];
    sample_t high_mark [3];
    sample_t offs [3];

    sample_vec_t sample_q [$];
    result_t     expected_stats_q [$];
    sample_vec_t run_seed;
    logic        s_taken    = 1'b0;
    bit          gaps_on    = 1'b1;
    int          mismatches = 0;
    int          idle_cycles = 0;

    string field_name [NUM_FIELDS] = '{"avg_x", "avg_y", "avg_z", "corr_x", "corr_y",
                                       "corr_z", "min_x", "min_y", "min_z", "max_x",
                                       "max_y", "max_z"};

    three_axis_moving_average_minmax_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic void clear_model();
        for (int ax = 0; ax < 3; ax++) begin
            for (int i = 0; i < WINDOW; i++) win[ax][i] = '0;
            low_mark[ax]  = '0;
            high_mark[ax] = '0;
            offs[ax]      = '0;
        end
    endfunction

    function automatic result_t predict_stats(sample_vec_t s);
        sample_t v [3];
        sample_t a [3];
        int      sum;
        result_t r;
        v[0] = s.x;
        v[1] = s.y;
        v[2] = s.z;
        for (int ax = 0; ax < 3; ax++) begin
            for (int i = 0; i < WINDOW - 1; i++) win[ax][i] = win[ax][i+1];
            win[ax][WINDOW-1] = v[ax];
            sum = 0;
            for (int i = 0; i < WINDOW; i++) sum += int'(win[ax][i]);
            // int division truncates toward zero
            a[ax] = sample_t'(sum / WINDOW);
            if (a[ax] < low_mark[ax]) low_mark[ax] = a[ax];
            if (a[ax] > high_mark[ax]) high_mark[ax] = a[ax];
        end
        r.avg_x  = a[0];
        r.avg_y  = a[1];
        r.avg_z  = a[2];
        r.corr_x = corr_t'(int'(a[0]) - int'(offs[0]));
        r.corr_y = corr_t'(int'(a[1]) - int'(offs[1]));
        r.corr_z = corr_t'(int'(a[2]) - int'(offs[2]));
        r.min_x  = low_mark[0];
        r.min_y  = low_mark[1];
        r.min_z  = low_mark[2];
        r.max_x  = high_mark[0];
        r.max_y  = high_mark[1];
        r.max_z  = high_mark[2];
        return r;
    endfunction

    function automatic field_arr_t to_fields(result_t r);
        field_arr_t f;
        f = '{int'(r.avg_x), int'(r.avg_y), int'(r.avg_z),
              int'(r.corr_x), int'(r.corr_y), int'(r.corr_z),
              int'(r.min_x), int'(r.min_y), int'(r.min_z),
              int'(r.max_x), int'(r.max_y), int'(r.max_z)};
        return f;
    endfunction

    function automatic sample_t pick_sample(int amp, sample_t prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return sample_t'($urandom);
        if (r < 40) return prev;
        return sample_t'(int'($urandom_range(0, 2 * amp)) - amp);
    endfunction

    // driver and sink, both change on the falling edge
    always @(negedge aclk) begin
        sample_vec_t next_item;
        if (aresetn) begin
            m_tready <= !(gaps_on && $urandom_range(0, 99) < 8);
            if (!s_tvalid || s_taken) begin
                if (sample_q.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 8)) begin
                    next_item = sample_q.pop_front();
                    s_tdata  <= S_TDATA_W'(next_item);
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: predict on input accept, check on output accept
    always @(posedge aclk) begin
        result_t    got;
        result_t    want;
        field_arr_t gf;
        field_arr_t wf;
        if (!aresetn) begin
            clear_model();
            s_taken <= 1'b0;
        end else begin
            s_taken <= s_tvalid && s_tready;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_OFFSET_X: offs[0] = sample_t'(cfg_wdata);
                    REG_OFFSET_Y: offs[1] = sample_t'(cfg_wdata);
                    REG_OFFSET_Z: offs[2] = sample_t'(cfg_wdata);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_stats_q.push_back(predict_stats(sample_vec_t'(s_tdata[SAMPLES_W-1:0])));
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[RESULT_W-1:0]);
                if (expected_stats_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("[%0t] unexpected result item: %h", $realtime, got);
                end else begin
                    want = expected_stats_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            gf = to_fields(got);
                            wf = to_fields(want);
                            for (int k = 0; k < NUM_FIELDS; k++)
                                if (gf[k] != wf[k])
                                    $display("[%0t] %s mismatch: expected %0d, got %0d",
                                             $realtime, field_name[k], wf[k], gf[k]);
                        end
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_sample(input sample_t x, input sample_t y, input sample_t z);
        sample_vec_t s;
        s.x = x;
        s.y = y;
        s.z = z;
        sample_q.push_back(s);
    endtask

    // hold the sender until every expected item is back, then let the pipe settle
    task automatic wait_drained();
        while (sample_q.size() != 0 || s_tvalid || expected_stats_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic load_random(input int count, input int amp, input bit with_runs,
                               input bit gaps);
        sample_vec_t s;
        sample_vec_t ext;
        int          n;
        @(posedge aclk);
        gaps_on = gaps;
        n = 0;
        while (n < count) begin
            // full windows of extremes drive averages and corrections to their limits
            if (with_runs && $urandom_range(0, 99) < 3) begin
                ext.x = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
                ext.y = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
                ext.z = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
                repeat (WINDOW + 2) sample_q.push_back(ext);
                n += WINDOW + 2;
            end else begin
                s.x = pick_sample(amp, run_seed.x);
                s.y = pick_sample(amp, run_seed.y);
                s.z = pick_sample(amp, run_seed.z);
                sample_q.push_back(s);
                run_seed = s;
                n++;
            end
        end
    endtask

    initial begin
        run_seed = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: offsets at reset, truncation of small sums, input extremes
        @(posedge aclk);
        push_sample(16'sd0, 16'sd0, 16'sd0);
        push_sample(16'sd15, -16'sd15, 16'sd9);
        push_sample(SAMPLE_MIN, SAMPLE_MAX, -16'sd9);
        push_sample(SAMPLE_MAX, SAMPLE_MIN, -16'sd1);
        push_sample(-16'sd1, -16'sd1, -16'sd1);
        push_sample(16'sd1, 16'sd1, 16'sd1);
        wait_drained();

        write_reg(REG_OFFSET_X, SAMPLE_MAX);
        write_reg(REG_OFFSET_Y, SAMPLE_MIN);
        write_reg(REG_OFFSET_Z, 16'hffff);
        write_reg(REG_NONE, 16'h5a5a);   // must be ignored
        @(posedge aclk);
        push_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
        push_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        push_sample(16'sh5555, -16'sh5556, 16'sh2aaa);
        push_sample(-16'sh2aab, 16'sh1234, -16'sh4321);
        push_sample(16'sd0, 16'sd0, 16'sd0);
        push_sample(-16'sd19, 16'sd19, 16'sd10);
        wait_drained();

        // random phases, amplitude grows so the marks keep moving
        write_reg(REG_OFFSET_X, CFG_W'($urandom));
        write_reg(REG_OFFSET_Y, CFG_W'($urandom));
        write_reg(REG_OFFSET_Z, CFG_W'($urandom));
        load_random(475, 1500, 1'b0, 1'b1);
        wait_drained();

        write_reg(REG_OFFSET_X, SAMPLE_MIN);
        write_reg(REG_OFFSET_Y, SAMPLE_MIN);
        write_reg(REG_OFFSET_Z, SAMPLE_MIN);
        write_reg(REG_NONE, CFG_W'($urandom));
        load_random(475, 7000, 1'b0, 1'b1);
        wait_drained();

        // long stretch with no gaps on either side
        write_reg(REG_OFFSET_X, CFG_W'($urandom));
        write_reg(REG_OFFSET_Y, CFG_W'($urandom));
        write_reg(REG_OFFSET_Z, SAMPLE_MAX);
        load_random(475, 20000, 1'b0, 1'b0);
        wait_drained();

        write_reg(REG_OFFSET_X, SAMPLE_MAX);
        write_reg(REG_OFFSET_Y, SAMPLE_MIN);
        write_reg(REG_OFFSET_Z, CFG_W'($urandom));
        load_random(475, 32767, 1'b1, 1'b1);
        wait_drained();

        mismatches += expected_stats_q.size();
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/tamam_pkg.sv
rtl/core/tamam_cell.sv
rtl/core/tamam_div.sv
rtl/core/tamam_track.sv
rtl/core/three_axis_moving_average_minmax_top.sv
rtl/core/tamam_checker.sv
tb/three_axis_moving_average_minmax_top_tb.sv
